// ===== src/hfau_pkg.sv =====
// ----------------------------------------------------------------------------
// hfau_pkg
// Shared types and constants for the binary16 add/mul unit.
// ----------------------------------------------------------------------------
package hfau_pkg;

    localparam int unsigned FracW = 10;
    localparam int unsigned ExpW  = 5;
    localparam int unsigned HalfW = 16;
    localparam int unsigned DefFifoDepth = 2;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_MAC = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [HalfW-1:0] value;
        logic             ovf;
        logic             unf;
    } t_res;

    // Request payload: command and operands a, b, c.
    typedef struct packed {
        t_cmd             cmd;
        logic [HalfW-1:0] a;
        logic [HalfW-1:0] b;
        logic [HalfW-1:0] c;
    } t_req;

endpackage

// ===== src/hfau_if.sv =====
// ----------------------------------------------------------------------------
// hfau_if
// Valid/ready channel carrying one payload of type T.
// ----------------------------------------------------------------------------
interface hfau_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/hfau_core.sv =====
// ----------------------------------------------------------------------------
// hfau_core
// Pipelined binary16 add or multiply: decode, align/multiply, add and
// normalize, round and pack. Four register stages, advancing on i_en.
// ----------------------------------------------------------------------------
module hfau_core
    import hfau_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic             i_mul,
    input  logic [HalfW-1:0] i_a,
    input  logic [HalfW-1:0] i_b,
    output logic             o_vld,
    output t_res             o_res
);
    // stage 1: decode, order, special case
    logic        sa, sb;
    logic [4:0]  ea, eb;
    logic        swp;
    logic        n_spec;
    logic [15:0] n_spec_val;
    always_comb begin
        sa = i_a[15];
        sb = i_b[15];
        ea = i_a[14:10];
        eb = i_b[14:10];
        swp = (i_a[14:0] < i_b[14:0]);
        n_spec = 1'b0;
        n_spec_val = '0;
        if (i_mul) begin
            if (ea == '0 || eb == '0) begin
                n_spec = 1'b1;
                n_spec_val = {sa ^ sb, 15'd0};
            end
        end else if (ea == '0 && eb == '0) begin
            n_spec = 1'b1;
            n_spec_val = {sa & sb, 15'd0};
        end else if (ea == '0) begin
            n_spec = 1'b1;
            n_spec_val = i_b;
        end else if (eb == '0) begin
            n_spec = 1'b1;
            n_spec_val = i_a;
        end
    end

    logic        r1_vld, r1_mul, r1_spec;
    logic [15:0] r1_spec_val, r1_x, r1_y;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
        end
        if (i_en) begin
            r1_mul      <= i_mul;
            r1_spec     <= n_spec;
            r1_spec_val <= n_spec_val;
            r1_x        <= (swp && !i_mul) ? i_b : i_a;
            r1_y        <= (swp && !i_mul) ? i_a : i_b;
        end
    end

    // stage 2: multiply or align, form 48-bit magnitude m and exponent base
    logic [10:0] mx, my;
    logic [4:0]  d;
    logic [23:0] myal;
    logic        lost;
    logic [47:0] n2_m;
    logic signed [7:0] n2_eb;
    always_comb begin
        mx = {1'b1, r1_x[9:0]};
        my = {1'b1, r1_y[9:0]};
        d  = r1_x[14:10] - r1_y[14:10];
        myal = '0;
        lost = 1'b0;
        if (d >= 5'd25) begin
            myal = 24'd1;
        end else begin
            myal = {my, 13'd0} >> d;
            lost = (({my, 13'd0} & ((24'd1 << d) - 24'd1)) != '0);
            myal[0] = myal[0] | lost;
        end
        if (r1_mul) begin
            n2_m  = {26'd0, 22'({11'd0, mx} * {11'd0, my})};
            n2_eb = 8'(signed'({3'd0, r1_x[14:10]}) + signed'({3'd0, r1_y[14:10]}))
                    - 8'sd35;
        end else begin
            if (r1_x[15] == r1_y[15]) begin
                n2_m = {24'd0, {mx, 13'd0}} + {24'd0, myal};
            end else begin
                n2_m = {24'd0, {mx, 13'd0}} - {24'd0, myal};
            end
            n2_eb = signed'({3'd0, r1_x[14:10]}) - 8'sd23;
        end
    end

    logic        r2_vld, r2_spec, r2_sign;
    logic [15:0] r2_spec_val;
    logic [47:0] r2_m;
    logic signed [7:0] r2_eb;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (i_en) begin
            r2_vld <= r1_vld;
        end
        if (i_en) begin
            r2_spec     <= r1_spec;
            r2_spec_val <= r1_spec_val;
            r2_sign     <= r1_mul ? (r1_x[15] ^ r1_y[15]) : r1_x[15];
            r2_m        <= n2_m;
            r2_eb       <= n2_eb;
        end
    end

    // stage 3: leading-one position, normalize to 11 bits + guard + sticky
    logic [4:0]  p;
    logic [24:0] sh;
    logic        n3_zero;
    always_comb begin
        p = '0;
        for (int i = 0; i < 25; i++) begin
            if (r2_m[i]) begin
                p = 5'(i);
            end
        end
        n3_zero = (r2_m[24:0] == '0);
        sh = r2_m[24:0] << (5'd24 - p);
    end

    logic        r3_vld, r3_spec, r3_sign, r3_zero;
    logic [15:0] r3_spec_val;
    logic [10:0] r3_keep;
    logic        r3_g, r3_st;
    logic signed [7:0] r3_e;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r3_vld <= r2_vld;
        end
        if (i_en) begin
            r3_spec     <= r2_spec;
            r3_spec_val <= r2_spec_val;
            r3_sign     <= r2_sign;
            r3_zero     <= n3_zero;
            r3_keep     <= sh[24:14];
            r3_g        <= sh[13];
            r3_st       <= (sh[12:0] != '0);
            r3_e        <= r2_eb + signed'({3'd0, p});
        end
    end

    // stage 4: round, renormalize, pack
    logic [11:0] kr;
    logic signed [7:0] e4;
    t_res n4_res;
    always_comb begin
        kr = {1'b0, r3_keep} + {11'd0, r3_g && (r3_st || r3_keep[0])};
        e4 = r3_e;
        if (kr[11]) begin
            kr = kr >> 1;
            e4 = e4 + 8'sd1;
        end
        n4_res = '0;
        if (r3_spec) begin
            n4_res.value = r3_spec_val;
        end else if (r3_zero) begin
            n4_res.value = '0;
        end else if (e4 >= 8'sd31) begin
            n4_res.value = {r3_sign, 15'h7C00};
            n4_res.ovf   = 1'b1;
        end else if (e4 <= 8'sd0) begin
            n4_res.value = {r3_sign, 15'd0};
            n4_res.unf   = 1'b1;
        end else begin
            n4_res.value = {r3_sign, e4[4:0], kr[9:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= r3_vld;
        end
        if (i_en) begin
            o_res <= n4_res;
        end
    end
endmodule

// ===== src/half_float_add_mul_unit.sv =====
// ----------------------------------------------------------------------------
// half_float_add_mul_unit
// binary16 add, subtract, multiply and multiply-then-add (product rounded).
// ----------------------------------------------------------------------------
// Usage:
//   s_req carries a transaction of command and operands a, b, c. m_res
//   returns result_value with overflow and underflow flags, one per
//   transaction, in order.
//   Two chained four-stage cores: first core multiplies b*c (MAC) or does
//   the whole operation; second core adds a to the product (MAC, unless
//   the product overflowed) or passes the first result. One transaction
//   is accepted every cycle unless the receiver stalls.
//   The pipeline advances whenever the output register is empty or being
//   taken; a receiver stall freezes all stages, nothing lost or repeated.
//   Reset clears all valid bits; no transaction is in flight afterwards.
// ----------------------------------------------------------------------------
module half_float_add_mul_unit
    import hfau_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    hfau_if.sink   s_req,
    hfau_if.source m_res
);
    logic en;
    logic v1, v2;
    t_res res1, res2;
    t_req req;

    assign req = s_req.data;
    assign en  = !m_res.valid || m_res.ready;
    assign s_req.ready = en;

    logic mul1;
    logic [15:0] a1, b1;
    always_comb begin
        mul1 = (req.cmd == CMD_MUL) || (req.cmd == CMD_MAC);
        a1 = (req.cmd == CMD_MAC) ? req.b : req.a;
        b1 = (req.cmd == CMD_MAC) ? req.c :
             (req.cmd == CMD_SUB) ? {~req.b[15], req.b[14:0]} : req.b;
    end

    hfau_core u_stage_a (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_vld(s_req.valid && en), .i_mul(mul1), .i_a(a1), .i_b(b1),
        .o_vld(v1), .o_res(res1)
    );

    // carry a and the MAC flag alongside the first core (4 stages)
    logic [3:0]  r_mac;
    logic [15:0] r_a [4];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mac <= {r_mac[2:0], req.cmd == CMD_MAC};
            r_a[0] <= req.a;
            for (int i = 1; i < 4; i++) begin
                r_a[i] <= r_a[i-1];
            end
        end
    end

    logic do_add;
    assign do_add = r_mac[3] && !res1.ovf;

    hfau_core u_stage_b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_vld(v1), .i_mul(1'b0), .i_a(r_a[3]), .i_b(res1.value),
        .o_vld(v2), .o_res(res2)
    );

    logic [3:0] r_add;
    t_res r_pass [4];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_add <= {r_add[2:0], do_add};
            r_pass[0] <= res1;
            for (int i = 1; i < 4; i++) begin
                r_pass[i] <= r_pass[i-1];
            end
        end
    end

    t_res fin;
    always_comb begin
        fin = r_pass[3];
        if (r_add[3]) begin
            fin.value = res2.value;
            fin.ovf   = res2.ovf;
            fin.unf   = res2.unf | r_pass[3].unf;
        end
    end

    assign m_res.valid = v2;
    assign m_res.data  = fin;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_res.valid && !m_res.ready) |=> m_res.valid && $stable(m_res.data))
        else $error("result changed under stall");
    a_no_acc_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_res.valid && !m_res.ready) |-> !s_req.ready)
        else $error("accepted while stalled");
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_res.valid |-> !(m_res.data.ovf && m_res.data.value[14:10] != 5'h1F))
        else $error("overflow without infinity");
endmodule
